>>> hw/rtl/indexed_list_engine_defines.svh
// ----------------------------------------------------------------------------
// indexed_list_engine_defines.svh
// Assertion macros for the indexed list engine.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define ILE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ile assertion failed");
`define ILE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ile assertion failed");
`else
`define ILE_ASSERT_SAME(label, clk, rst, ante, cons)
`define ILE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> hw/rtl/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Types, codes and helpers shared by the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_WORD_WIDTH = 64;

  localparam int IDX_W   = 7;
  localparam int VAL_W   = 64;
  localparam int POS_W   = 6;
  localparam int CNT_W   = 7;
  localparam int GROUP   = 8;
  localparam int GROUP_W = 3;

  typedef enum logic [2:0] {
    ACT_CLEAR  = 3'd0,
    ACT_READ   = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_FIND   = 3'd4
  } ile_action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } ile_status_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } ile_state_e;

  typedef struct packed {
    logic [2:0]       action;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
  } ile_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] data_out;
    logic [POS_W-1:0] position;
    logic             hit;
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
  } ile_out_t;

  typedef struct packed {
    logic insert;
    logic remove;
  } ile_cell_ctrl_t;

  typedef struct packed {
    logic found;
    logic last;
  } ile_scan_t;

  function automatic logic [GROUP_W-1:0] first_one(input logic [GROUP-1:0] v);
    logic [GROUP_W-1:0] r;
    r = '0;
    for (int k = GROUP - 1; k >= 0; k--) begin
      if (v[k]) r = GROUP_W'(k);
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/ile_cell.sv
// ----------------------------------------------------------------------------
// ile_cell
// One list slot: holds a word, shifts from a neighbor, compares for find.
// ----------------------------------------------------------------------------
module ile_cell import ile_pkg::*; #(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH,
  parameter int CW         = 8,
  parameter int POS        = 0
) (
  input  logic                  clk,
  input  ile_cell_ctrl_t        ctrl,
  input  logic [CW-1:0]         idx,
  input  logic [CW-1:0]         fill,
  input  logic [WORD_WIDTH-1:0] value,
  input  logic [WORD_WIDTH-1:0] left,
  input  logic [WORD_WIDTH-1:0] right,
  output logic [WORD_WIDTH-1:0] word,
  output logic [WORD_WIDTH-1:0] rd,
  output logic                  match
);

  localparam logic [CW-1:0] MY_POS = CW'(POS);

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (MY_POS == idx) word <= value;
      else if (MY_POS > idx) word <= left;
    end else if (ctrl.remove && (MY_POS >= idx)) begin
      word <= right;
    end
  end

  assign rd    = word & {WORD_WIDTH{MY_POS == idx}};
  assign match = (MY_POS < fill) && (word == value);

endmodule

>>> hw/rtl/ile_scan.sv
// ----------------------------------------------------------------------------
// ile_scan
// Holds the match flags of a find and walks them one group per cycle.
// ----------------------------------------------------------------------------
module ile_scan import ile_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int AW       = 7
) (
  input  logic                clk,
  input  logic                load,
  input  logic                step,
  input  logic [CAPACITY-1:0] match_in,
  output ile_scan_t           stat,
  output logic [AW-1:0]       pos
);

  localparam int NG     = (CAPACITY + GROUP - 1) / GROUP;
  localparam int PADDED = NG * GROUP;
  localparam int GW     = (NG > 1) ? $clog2(NG) : 1;

  logic [PADDED-1:0] flags;
  logic [GW-1:0]     grp;

  always_ff @(posedge clk) begin
    if (load) begin
      flags <= PADDED'(match_in);
      grp   <= '0;
    end else if (step) begin
      flags <= flags >> GROUP;
      grp   <= grp + GW'(1);
    end
  end

  assign stat.found = |flags[GROUP-1:0];
  assign stat.last  = (grp == GW'(NG - 1));
  assign pos        = AW'({grp, first_one(flags[GROUP-1:0])});

endmodule

>>> hw/rtl/indexed_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_list_engine
// Bounded ordered list of words held in a row of cells.
// ----------------------------------------------------------------------------
// Clear, read, insert and remove: a word is taken whenever busy is low and
// its result is shown with done in the next cycle. For find, all cells
// compare in the accept cycle, then the match flags are scanned eight cells
// per cycle, busy staying high until the result is issued. Results cannot
// be stalled. No clearing pass after reset.
`include "indexed_list_engine_defines.svh"

module indexed_list_engine import ile_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  ile_in_t  cmd,
  output logic     done,
  output ile_out_t rsp
);

  localparam int AW = $clog2(CAPACITY + 1);
  localparam int CW = (AW > IDX_W) ? AW : IDX_W;

  ile_state_e state, state_next;
  logic [AW-1:0] fill, fill_next;

  logic                  accept, quick, scan_step, finish;
  logic [CW-1:0]         idx_c, fill_c;
  logic [WORD_WIDTH-1:0] value_w;
  logic                  rd_ok, ins_range, full;
  ile_cell_ctrl_t        cell_ctrl;
  ile_out_t              rsp_c;
  ile_out_t              rsp_f;

  logic [WORD_WIDTH-1:0] words [CAPACITY];
  logic [WORD_WIDTH-1:0] rds   [CAPACITY];
  logic [CAPACITY-1:0]   match;
  logic [WORD_WIDTH-1:0] rd_word;

  ile_scan_t     scan_stat;
  logic [AW-1:0] scan_pos;

  assign accept  = start && !busy;
  assign quick   = accept && (cmd.action != ACT_FIND);
  assign idx_c   = CW'(cmd.index);
  assign fill_c  = CW'(fill);
  assign value_w = cmd.value[WORD_WIDTH-1:0];

  assign rd_ok     = idx_c < fill_c;
  assign ins_range = idx_c > fill_c;
  assign full      = (fill == AW'(CAPACITY));

  assign cell_ctrl.insert = accept && (cmd.action == ACT_INSERT) && !ins_range && !full;
  assign cell_ctrl.remove = accept && (cmd.action == ACT_REMOVE) && rd_ok;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = words[i+1];
    end
    ile_cell #(.WORD_WIDTH(WORD_WIDTH), .CW(CW), .POS(i)) u_cell (
      .clk   (clk),
      .ctrl  (cell_ctrl),
      .idx   (idx_c),
      .fill  (fill_c),
      .value (value_w),
      .left  (left),
      .right (right),
      .word  (words[i]),
      .rd    (rds[i]),
      .match (match[i])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) rd_word = rd_word | rds[i];
  end

  ile_scan #(.CAPACITY(CAPACITY), .AW(AW)) u_scan (
    .clk      (clk),
    .load     (accept && (cmd.action == ACT_FIND)),
    .step     (scan_step),
    .match_in (match),
    .stat     (scan_stat),
    .pos      (scan_pos)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && (cmd.action == ACT_FIND)) state_next = ST_SCAN;
      ST_SCAN: if (scan_stat.found || scan_stat.last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = 1'b0;
    scan_step = 1'b0;
    unique case (state)
      ST_IDLE: busy = 1'b0;
      ST_SCAN: begin
        busy      = 1'b1;
        scan_step = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  assign finish = scan_step && (scan_stat.found || scan_stat.last);

  always_comb begin
    fill_next      = fill;
    rsp_c          = '0;
    unique case (cmd.action)
      ACT_CLEAR: fill_next = '0;
      ACT_READ: begin
        if (rd_ok) rsp_c.data_out = VAL_W'(rd_word);
        else rsp_c.status = STAT_RANGE;
      end
      ACT_INSERT: begin
        if (ins_range) rsp_c.status = STAT_RANGE;
        else if (full) rsp_c.status = STAT_FULL;
        else fill_next = fill + AW'(1);
      end
      ACT_REMOVE: begin
        if (rd_ok) fill_next = fill - AW'(1);
        else rsp_c.status = STAT_RANGE;
      end
      default: rsp_c.status = STAT_OK;
    endcase
    rsp_c.count = CNT_W'(fill_next);
  end

  always_comb begin
    rsp_f          = '0;
    rsp_f.hit      = scan_stat.found;
    rsp_f.position = scan_stat.found ? POS_W'(scan_pos) : '0;
    rsp_f.status   = STAT_OK;
    rsp_f.count    = CNT_W'(fill);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish || quick;
      if (finish) begin
        rsp <= rsp_f;
      end else if (quick) begin
        rsp  <= rsp_c;
        fill <= fill_next;
      end
    end
  end

  `ILE_ASSERT_SAME(a_no_done_in_scan, clk, rst, busy, !done)
  `ILE_ASSERT_SAME(a_fill_bound, clk, rst, 1'b1, fill <= AW'(CAPACITY))
  `ILE_ASSERT_NEXT(a_quick_result, clk, rst, accept && (cmd.action != ACT_FIND), done)
  `ILE_ASSERT_NEXT(a_find_result, clk, rst, finish, done && !busy)

endmodule
